/* rtl/core/mhpq_pkg.sv */
`default_nettype none

package mhpq_pkg;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned TOTAL_W = 7;

  localparam logic signed [KEY_W-1:0] EMPTY_KEY = -32'sd2;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } mhpq_op_e;

  // Broadcast to every cell in the cycle an item is taken.
  typedef struct packed {
    logic                    push;
    logic                    pop;
    logic signed [KEY_W-1:0] key;
  } mhpq_cmd_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic                    gt;
    logic                    valid;
    logic signed [KEY_W-1:0] key;
  } mhpq_link_t;

endpackage

`default_nettype wire

/* rtl/core/mhpq_if.sv */
`default_nettype none

interface mhpq_in_if
  import mhpq_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic signed [KEY_W-1:0] key_in;

  modport source (output valid, output opcode, output key_in, input ready);
  modport sink (input valid, input opcode, input key_in, output ready);
endinterface

interface mhpq_out_if
  import mhpq_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] min_key;
  logic                    is_empty;
  logic [TOTAL_W-1:0]      entry_total;
  logic                    overflow;

  modport source (output valid, output min_key, output is_empty, output entry_total,
                  output overflow, input ready);
  modport sink (input valid, input min_key, input is_empty, input entry_total,
                input overflow, output ready);
endinterface

`default_nettype wire

/* rtl/core/mhpq_cell.sv */
`default_nettype none

module mhpq_cell
  import mhpq_pkg::*;
#(
  parameter int unsigned CNT_W = 7,
  parameter int unsigned IDX   = 0
) (
  input  wire logic             clk_i,
  input  wire mhpq_cmd_t        cmd_i,
  input  wire mhpq_link_t       left_i,
  input  wire mhpq_link_t       right_i,
  input  wire logic [CNT_W-1:0] count_i,
  output mhpq_link_t            link_o
);

  logic signed [KEY_W-1:0] key_q, key_d;
  logic                    own_valid;
  logic                    gt;

  // Occupancy follows from the fill count; empty cells act as +infinity.
  assign own_valid = count_i > CNT_W'(IDX);
  assign gt        = !own_valid || ($signed(cmd_i.key) < $signed(key_q));

  assign link_o.gt    = gt;
  assign link_o.valid = own_valid;
  assign link_o.key   = key_q;

  always_comb begin
    key_d = key_q;
    if (cmd_i.push) begin
      if (left_i.gt) begin
        key_d = left_i.key;
      end else if (gt) begin
        key_d = cmd_i.key;
      end
    end else if (cmd_i.pop) begin
      key_d = right_i.key;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

`default_nettype wire

/* rtl/core/min_heap_priority_queue.sv */
`default_nettype none

// Priority queue of signed 32-bit keys, CAPACITY deep, smallest key first.
// Each input item is a push (opcode 0) or a pop of the minimum (opcode 1) and
// yields exactly one result item: the smallest key held after the operation
// (-2 when empty), an empty flag, the stored count modulo 128, and an overflow
// flag set only when a push found the queue full and was dropped. A pop on an
// empty queue changes nothing. The keys sit sorted in a row of CAPACITY cells;
// a push makes every cell compare against the new key at once and shift right
// of the insert point, a pop shifts the whole row left by one. Each item is
// accepted while the output register is empty or being drained, and its result
// appears in that register on the next cycle, so while results are drained the
// sustained rate is one item per cycle. No clearing pass is needed after
// reset; occupancy comes from the fill count alone.
module min_heap_priority_queue
  import mhpq_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mhpq_in_if.sink   in_i,
  mhpq_out_if.source out_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]        count_q, count_d;
  logic                    out_valid_q;
  logic signed [KEY_W-1:0] min_key_q, min_key_d;
  logic                    is_empty_q;
  logic [TOTAL_W-1:0]      total_q;
  logic                    overflow_q, overflow_d;

  logic                    in_fire;
  logic                    full;
  mhpq_cmd_t               cmd;
  mhpq_link_t              links [CAPACITY];
  mhpq_link_t              edge_link;
  logic signed [KEY_W-1:0] head_d;

  // Take a new item whenever the result register is free or being drained.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;
  assign full       = count_q == CNT_W'(CAPACITY);

  assign cmd.push = in_fire && (in_i.opcode == OP_PUSH) && !full;
  assign cmd.pop  = in_fire && (in_i.opcode == OP_POP) && (count_q != '0);
  assign cmd.key  = in_i.key_in;

  // Boundary neighbor: nothing shifts in from the left, an empty slot from the right.
  assign edge_link.gt    = 1'b0;
  assign edge_link.valid = 1'b0;
  assign edge_link.key   = EMPTY_KEY;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    mhpq_link_t left_link, right_link;
    if (i == 0) begin : g_first
      assign left_link = edge_link;
    end else begin : g_mid_l
      assign left_link = links[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_link = edge_link;
    end else begin : g_mid_r
      assign right_link = links[i+1];
    end
    mhpq_cell #(
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .left_i  (left_link),
      .right_i (right_link),
      .count_i (count_q),
      .link_o  (links[i])
    );
  end

  // Next head of the row, mirroring what cell zero will load.
  always_comb begin
    head_d = links[0].key;
    if (cmd.push) begin
      if (links[0].gt) begin
        head_d = cmd.key;
      end
    end else if (cmd.pop) begin
      head_d = links[1].key;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd.push) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd.pop) begin
      count_d = count_q - CNT_W'(1);
    end
    overflow_d = in_fire && (in_i.opcode == OP_PUSH) && full;
    min_key_d  = (count_d == '0) ? EMPTY_KEY : head_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result payload until the next item replaces it.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      min_key_q  <= min_key_d;
      is_empty_q <= count_d == '0;
      total_q    <= TOTAL_W'(count_d);
      overflow_q <= overflow_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.min_key     = min_key_q;
  assign out_o.is_empty    = is_empty_q;
  assign out_o.entry_total = total_q;
  assign out_o.overflow    = overflow_q;

`ifndef SYNTH
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_pop_dec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_i.opcode == OP_POP) && (count_q != '0)
    |=> count_q == $past(count_q) - CNT_W'(1))
    else $error("pop did not remove one entry");

  a_head_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    links[1].valid |-> $signed(links[0].key) <= $signed(links[1].key))
    else $error("head cell is not the minimum");

  a_overflow_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && overflow_d |=> count_q == CNT_W'(CAPACITY) && out_o.overflow)
    else $error("overflow reported while not full");
`endif

endmodule

`default_nettype wire

/* verif/min_heap_priority_queue_checker.sv */
`default_nettype none

module min_heap_priority_queue_checker
  import mhpq_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mhpq_in_if        in_i,
  mhpq_out_if       out_i,
  output int        fail_count_o,
  output int        backlog_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [KEY_W-1:0] min_key;
    logic                    is_empty;
    logic [TOTAL_W-1:0]      entry_total;
    logic                    overflow;
  } heap_result_t;

  // Shadow heap: root at 0, children of i at 2i+1 and 2i+2.
  logic signed [KEY_W-1:0] heap_keys [CAPACITY];
  int                      heap_fill = 0;

  heap_result_t            expected_results [$];
  int                      mismatch_total = 0;
  int                      pending_total = 0;

  assign fail_count_o = mismatch_total;
  assign backlog_o    = pending_total;

  // Apply one push or pop to the shadow heap and return its result.
  function automatic heap_result_t apply_item(mhpq_op_e op, logic signed [KEY_W-1:0] key);
    heap_result_t            res;
    logic signed [KEY_W-1:0] tmp;
    logic                    dropped;
    int                      pos;
    int                      up;
    int                      lc;
    int                      rc;
    int                      pick;
    dropped = 1'b0;
    if (op == OP_PUSH) begin
      if (heap_fill >= CAPACITY) begin
        dropped = 1'b1;
      end else begin
        heap_keys[heap_fill] = key;
        heap_fill++;
        pos = heap_fill - 1;
        // Move up while the parent is strictly greater.
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (heap_keys[up] <= heap_keys[pos]) break;
          tmp = heap_keys[up];
          heap_keys[up] = heap_keys[pos];
          heap_keys[pos] = tmp;
          pos = up;
        end
      end
    end else if (heap_fill > 0) begin
      heap_fill--;
      if (heap_fill > 0) begin
        heap_keys[0] = heap_keys[heap_fill];
        pos = 0;
        // Take the smaller child, left on a tie; swap only if strictly smaller.
        forever begin
          lc = 2 * pos + 1;
          rc = lc + 1;
          if (lc >= heap_fill) break;
          pick = lc;
          if (rc < heap_fill && heap_keys[rc] < heap_keys[lc]) pick = rc;
          if (heap_keys[pick] >= heap_keys[pos]) break;
          tmp = heap_keys[pick];
          heap_keys[pick] = heap_keys[pos];
          heap_keys[pos] = tmp;
          pos = pick;
        end
      end
    end
    res.min_key     = (heap_fill > 0) ? heap_keys[0] : EMPTY_KEY;
    res.is_empty    = (heap_fill == 0);
    res.entry_total = TOTAL_W'(heap_fill);
    res.overflow    = dropped;
    return res;
  endfunction

  always @(posedge clk_i) begin
    heap_result_t want;
    if (rst_ni) begin
      if (in_i.valid && in_i.ready) begin
        expected_results.push_back(apply_item(mhpq_op_e'(in_i.opcode), in_i.key_in));
      end
      if (out_i.valid && out_i.ready) begin
        if (expected_results.size() == 0) begin
          $error("result item with no expectation pending");
          mismatch_total++;
        end else begin
          want = expected_results.pop_front();
          if (out_i.min_key !== want.min_key) begin
            $error("min_key: expected %0d, got %0d", want.min_key, out_i.min_key);
            mismatch_total++;
          end
          if (out_i.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0b, got %0b", want.is_empty, out_i.is_empty);
            mismatch_total++;
          end
          if (out_i.entry_total !== want.entry_total) begin
            $error("entry_total: expected %0d, got %0d", want.entry_total,
                   out_i.entry_total);
            mismatch_total++;
          end
          if (out_i.overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, out_i.overflow);
            mismatch_total++;
          end
        end
      end
      pending_total = expected_results.size();
    end
  end

endmodule

`default_nettype wire

/* verif/min_heap_priority_queue_tb.sv */
`default_nettype none

module min_heap_priority_queue_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import mhpq_pkg::*;

  localparam int unsigned CAPACITY    = 64;
  // Random part: phases of fill-heavy, drain-heavy and balanced traffic.
  localparam int          PHASE_COUNT = 16;
  localparam int          PHASE_ITEMS = 100;
  // Long receiver hold-off that backs the queue up into its input.
  localparam int          HOLD_AFTER  = 500;
  localparam int          HOLD_CYCLES = 300;

  logic clk_i = 1'b0;
  logic rst_ni;

  int   items_sent = 0;
  bit   calm_phase = 1'b0;
  int   mismatches;
  int   backlog;

  mhpq_in_if  in_if ();
  mhpq_out_if out_if ();

  always #5 clk_i = ~clk_i;

  min_heap_priority_queue #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  min_heap_priority_queue_checker #(
    .CAPACITY(CAPACITY)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_i       (out_if),
    .fail_count_o(mismatches),
    .backlog_o   (backlog)
  );

  // Idle length: mostly none, often a few cycles, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Key mix: full-range values for bit coverage, a narrow band for ties,
  // the two extremes, the empty marker itself, and values near the extremes.
  function automatic logic signed [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom();
      4, 5, 6:    return $signed(32'($urandom_range(0, 15))) - 32'sd8;
      7:          return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      8:          return EMPTY_KEY;
      default: begin
        if ($urandom_range(0, 1)) return 32'sh7FFF_FFF0 + $urandom_range(0, 15);
        return 32'sh8000_0000 + $urandom_range(0, 15);
      end
    endcase
  endfunction

  // Offer one item and hold it until the queue takes it. Before raising
  // valid, optionally idle; junk payload on the idle cycles must be ignored.
  task automatic send_item(input mhpq_op_e op, input logic signed [KEY_W-1:0] key);
    int gap;
    gap = calm_phase ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_if.valid  <= 1'b0;
      in_if.opcode <= 1'($urandom_range(0, 1));
      in_if.key_in <= $urandom();
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_if.valid  <= 1'b1;
    in_if.opcode <= op;
    in_if.key_in <= key;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    items_sent++;
  endtask

  // Result side: random stalls, none during calm phases, and one long
  // hold-off once the run is well underway so the queue stalls its input.
  initial begin : result_drain
    int stall_left;
    bit hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (!hold_done && items_sent >= HOLD_AFTER) begin
        hold_done  = 1'b1;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && !calm_phase && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int pop_pct;
    mhpq_op_e op;
    in_if.valid  <= 1'b0;
    in_if.opcode <= OP_PUSH;
    in_if.key_in <= '0;
    rst_ni       <= 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: pop on empty, a stored key equal to the empty marker,
    // popping the single entry, both extremes, ties, and draining to empty.
    send_item(OP_POP,  32'sh1234_5678);
    send_item(OP_PUSH, EMPTY_KEY);
    send_item(OP_POP,  '0);
    send_item(OP_POP,  '0);
    send_item(OP_PUSH, 32'sh7FFF_FFFF);
    send_item(OP_PUSH, 32'sh8000_0000);
    send_item(OP_PUSH, 32'sh0000_0000);
    send_item(OP_PUSH, -32'sd1);
    send_item(OP_PUSH, EMPTY_KEY);
    send_item(OP_PUSH, 32'sd5);
    send_item(OP_PUSH, 32'sd5);
    send_item(OP_PUSH, 32'sh8000_0000);
    repeat (9) send_item(OP_POP, $urandom());

    // Random: fill-heavy phases run into overflow, drain-heavy ones hit
    // empty pops, balanced ones stir the middle. Every fourth phase idles
    // neither side.
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      calm_phase = (phase % 4 == 3);
      case (phase % 3)
        0:       pop_pct = 15;
        1:       pop_pct = 85;
        default: pop_pct = 50;
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        op = ($urandom_range(0, 99) < pop_pct) ? OP_POP : OP_PUSH;
        send_item(op, pick_key());
      end
    end
    calm_phase = 1'b0;

    @(negedge clk_i);
    in_if.valid <= 1'b0;

    // Drain: wait for every expected result, then give the queue a few
    // cycles to show any stray extra result.
    wait (backlog == 0);
    repeat (20) @(posedge clk_i);

    if (mismatches == 0 && backlog == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run.
  initial begin : watchdog
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
